/* design/i2cm_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
package i2cm_pkg;

  // Command codes carried in func.
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_SEND  = 3'd2;
  localparam logic [2:0] FUNC_WACK  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_TICKS_PER_UNIT = 1'b0;
  localparam logic CFG_ACK_TIMEOUT    = 1'b1;

  // Register reset values.
  localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

  // Bits per byte on the bus.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam int DLY_W = 11;

  typedef enum logic [15:0] {
    PH_IDLE    = 16'b0000_0000_0000_0001,
    PH_ST_A    = 16'b0000_0000_0000_0010,
    PH_ST_B    = 16'b0000_0000_0000_0100,
    PH_SP_A    = 16'b0000_0000_0000_1000,
    PH_SP_B    = 16'b0000_0000_0001_0000,
    PH_SP_C    = 16'b0000_0000_0010_0000,
    PH_WA_A    = 16'b0000_0000_0100_0000,
    PH_WA_B    = 16'b0000_0000_1000_0000,
    PH_WA_POLL = 16'b0000_0001_0000_0000,
    PH_TX_SET  = 16'b0000_0010_0000_0000,
    PH_TX_HIGH = 16'b0000_0100_0000_0000,
    PH_TX_LOW  = 16'b0000_1000_0000_0000,
    PH_RX_LOW  = 16'b0001_0000_0000_0000,
    PH_RX_HIGH = 16'b0010_0000_0000_0000,
    PH_AK_SET  = 16'b0100_0000_0000_0000,
    PH_AK_HIGH = 16'b1000_0000_0000_0000
  } phase_t;

  // One result beat.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       err;
  } result_t;

endpackage

/* design/i2cm_core.sv */
// Bus phase sequencer: state registers and per-tick next-state logic.
module i2cm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cmd_valid,
  input  logic [2:0]        func,
  input  logic [7:0]        tx_byte,
  input  logic              ack_after_read,
  input  logic              sda_in,
  input  logic [7:0]        ticks_per_unit,
  input  logic [7:0]        ack_timeout,
  output i2cm_pkg::result_t result
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [2:0]  current_command, current_command_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [i2cm_pkg::DLY_W-1:0] delay_count, delay_count_next;
  logic [7:0]  tx_shift, tx_shift_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        ack_choice, ack_choice_next;
  logic        scl_level, scl_level_next;
  logic        sda_level, sda_level_next;
  logic        err_flag, err_flag_next;
  logic        done;

  logic [7:0]  tpu;
  logic [i2cm_pkg::DLY_W-1:0] dly1, dly2, dly4, dc_dec;
  logic [3:0]  bit_inc;

  // zero scale counts as one
  assign tpu  = (ticks_per_unit == 8'd0) ? 8'd1 : ticks_per_unit;
  assign dly1 = {3'b000, tpu};
  assign dly2 = {2'b00, tpu, 1'b0};
  assign dly4 = {1'b0, tpu, 2'b00};

  assign dc_dec  = (delay_count != '0) ? delay_count - 1'b1 : delay_count;
  assign bit_inc = bit_count + 4'd1;

  always_comb begin
    phase_next           = phase;
    current_command_next = current_command;
    bit_count_next       = bit_count;
    delay_count_next     = delay_count;
    tx_shift_next        = tx_shift;
    rx_shift_next        = rx_shift;
    poll_count_next      = poll_count;
    ack_choice_next      = ack_choice;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    err_flag_next        = err_flag;
    done                 = 1'b0;

    unique case (phase)
      i2cm_pkg::PH_IDLE: begin
        if (cmd_valid && func <= i2cm_pkg::FUNC_READ) begin
          current_command_next = func;
          unique case (func)
            i2cm_pkg::FUNC_START: begin
              sda_level_next   = 1'b1;
              scl_level_next   = 1'b1;
              delay_count_next = dly4;
              phase_next       = i2cm_pkg::PH_ST_A;
            end
            i2cm_pkg::FUNC_STOP: begin
              scl_level_next   = 1'b0;
              sda_level_next   = 1'b0;
              delay_count_next = dly4;
              phase_next       = i2cm_pkg::PH_SP_A;
            end
            i2cm_pkg::FUNC_SEND: begin
              scl_level_next   = 1'b0;
              bit_count_next   = 4'd0;
              sda_level_next   = tx_byte[7];
              tx_shift_next    = {tx_byte[6:0], 1'b0};
              delay_count_next = dly2;
              phase_next       = i2cm_pkg::PH_TX_SET;
            end
            i2cm_pkg::FUNC_WACK: begin
              err_flag_next    = 1'b0;
              poll_count_next  = 8'd0;
              sda_level_next   = 1'b1;
              delay_count_next = dly1;
              phase_next       = i2cm_pkg::PH_WA_A;
            end
            default: begin
              sda_level_next   = 1'b1;
              scl_level_next   = 1'b0;
              rx_shift_next    = 8'd0;
              bit_count_next   = 4'd0;
              ack_choice_next  = ack_after_read;
              delay_count_next = dly2;
              phase_next       = i2cm_pkg::PH_RX_LOW;
            end
          endcase
        end
      end
      i2cm_pkg::PH_WA_POLL: begin
        if (!sda_in) begin
          scl_level_next = 1'b0;
          phase_next     = i2cm_pkg::PH_IDLE;
          done           = 1'b1;
        end else if (poll_count >= ack_timeout) begin
          // timed out: fall into a stop condition
          scl_level_next   = 1'b0;
          sda_level_next   = 1'b0;
          delay_count_next = dly4;
          phase_next       = i2cm_pkg::PH_SP_A;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      default: begin
        delay_count_next = dc_dec;
        if (dc_dec == '0) begin
          unique case (phase)
            i2cm_pkg::PH_ST_A: begin
              sda_level_next   = 1'b0;
              delay_count_next = dly4;
              phase_next       = i2cm_pkg::PH_ST_B;
            end
            i2cm_pkg::PH_ST_B: begin
              scl_level_next = 1'b0;
              phase_next     = i2cm_pkg::PH_IDLE;
              done           = 1'b1;
            end
            i2cm_pkg::PH_SP_A: begin
              scl_level_next   = 1'b1;
              delay_count_next = {{(i2cm_pkg::DLY_W-1){1'b0}}, 1'b1};
              phase_next       = i2cm_pkg::PH_SP_B;
            end
            i2cm_pkg::PH_SP_B: begin
              sda_level_next   = 1'b1;
              delay_count_next = dly4;
              phase_next       = i2cm_pkg::PH_SP_C;
            end
            i2cm_pkg::PH_SP_C: begin
              if (current_command == i2cm_pkg::FUNC_WACK) err_flag_next = 1'b1;
              phase_next = i2cm_pkg::PH_IDLE;
              done       = 1'b1;
            end
            i2cm_pkg::PH_WA_A: begin
              scl_level_next   = 1'b1;
              delay_count_next = dly1;
              phase_next       = i2cm_pkg::PH_WA_B;
            end
            i2cm_pkg::PH_WA_B: begin
              poll_count_next = 8'd0;
              phase_next      = i2cm_pkg::PH_WA_POLL;
            end
            i2cm_pkg::PH_TX_SET: begin
              scl_level_next   = 1'b1;
              delay_count_next = dly2;
              phase_next       = i2cm_pkg::PH_TX_HIGH;
            end
            i2cm_pkg::PH_TX_HIGH: begin
              scl_level_next   = 1'b0;
              delay_count_next = dly2;
              phase_next       = i2cm_pkg::PH_TX_LOW;
            end
            i2cm_pkg::PH_TX_LOW: begin
              bit_count_next = bit_inc;
              if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
                phase_next = i2cm_pkg::PH_IDLE;
                done       = 1'b1;
              end else begin
                sda_level_next   = tx_shift[7];
                tx_shift_next    = {tx_shift[6:0], 1'b0};
                delay_count_next = dly2;
                phase_next       = i2cm_pkg::PH_TX_SET;
              end
            end
            i2cm_pkg::PH_RX_LOW: begin
              scl_level_next   = 1'b1;
              rx_shift_next    = {rx_shift[6:0], sda_in};
              bit_count_next   = bit_inc;
              delay_count_next = dly1;
              phase_next       = i2cm_pkg::PH_RX_HIGH;
            end
            i2cm_pkg::PH_RX_HIGH: begin
              scl_level_next   = 1'b0;
              delay_count_next = dly2;
              if (bit_count >= i2cm_pkg::BITS_PER_BYTE) begin
                sda_level_next = !ack_choice;
                phase_next     = i2cm_pkg::PH_AK_SET;
              end else begin
                phase_next     = i2cm_pkg::PH_RX_LOW;
              end
            end
            i2cm_pkg::PH_AK_SET: begin
              scl_level_next   = 1'b1;
              delay_count_next = dly2;
              phase_next       = i2cm_pkg::PH_AK_HIGH;
            end
            i2cm_pkg::PH_AK_HIGH: begin
              scl_level_next = 1'b0;
              phase_next     = i2cm_pkg::PH_IDLE;
              done           = 1'b1;
            end
            default: phase_next = i2cm_pkg::PH_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cm_pkg::PH_IDLE;
      current_command <= 3'd0;
      bit_count       <= 4'd0;
      delay_count     <= '0;
      tx_shift        <= 8'd0;
      rx_shift        <= 8'd0;
      poll_count      <= 8'd0;
      ack_choice      <= 1'b0;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      err_flag        <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      current_command <= current_command_next;
      bit_count       <= bit_count_next;
      delay_count     <= delay_count_next;
      tx_shift        <= tx_shift_next;
      rx_shift        <= rx_shift_next;
      poll_count      <= poll_count_next;
      ack_choice      <= ack_choice_next;
      scl_level       <= scl_level_next;
      sda_level       <= sda_level_next;
      err_flag        <= err_flag_next;
    end
  end

  // levels after this tick's update
  assign result.scl  = scl_level_next;
  assign result.sda  = sda_level_next;
  assign result.busy = (phase_next != i2cm_pkg::PH_IDLE);
  assign result.done = done;
  assign result.rx   = rx_shift_next;
  assign result.err  = err_flag_next;

endmodule

/* design/i2c_master_bit_sequencer.sv */
// Top level of the I2C master bit sequencer: config registers, core, output skid.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat per time tick of the bus.
//   A beat carries the sampled SDA level and an optional command (cmd_valid,
//   func, tx_byte, ack_after_read). Commands offered while busy are dropped.
//   Output channel (out_valid / out_stall): exactly one beat per input beat,
//   with the SCL/SDA pin levels after that tick, busy/done flags, the receive
//   shift register and the ack-timeout flag.
//   A result is registered in the output register, or in the skid register
//   while the output stalls. Throughput: one beat per cycle; the sequencer
//   steps on each accepted beat, so the sole limit is the output taking beats.
//   Stall: the output register plus a one-beat skid register let one more
//   beat in after the receiver stalls; in_stall rises once the skid is full.
//   Reset (rst, synchronous): sequencer idle, SCL and SDA released high,
//   ticks_per_unit = 1, ack_timeout = 250, both channels empty.
//   Config: cfg_wr_en writes cfg_data[7:0] into register cfg_index
//   (0 ticks_per_unit, 1 ack_timeout); write only while idle.
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd_valid,
  input  logic [2:0] func,
  input  logic [7:0] tx_byte,
  input  logic       ack_after_read,
  input  logic       sda_in,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_out,
  output logic       sda_release,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_error
);

  logic [7:0] ticks_per_unit;
  logic [7:0] ack_timeout;

  logic       accept;
  logic       out_free;
  logic       skid_valid;
  i2cm_pkg::result_t res, out_data, skid_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= i2cm_pkg::TICKS_PER_UNIT_RST;
      ack_timeout    <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == i2cm_pkg::CFG_TICKS_PER_UNIT) ticks_per_unit <= cfg_data;
      else ack_timeout <= cfg_data;
    end
  end

  // A beat enters whenever the skid slot is empty.
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  i2cm_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd_valid      (cmd_valid),
    .func           (func),
    .tx_byte        (tx_byte),
    .ack_after_read (ack_after_read),
    .sda_in         (sda_in),
    .ticks_per_unit (ticks_per_unit),
    .ack_timeout    (ack_timeout),
    .result         (res)
  );

  // Output register with a one-beat skid behind it.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) out_data <= skid_data;
      else if (accept) out_data <= res;
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign scl_out     = out_data.scl;
  assign sda_release = out_data.sda;
  assign busy_res    = out_data.busy;
  assign done_res    = out_data.done;
  assign rx_byte     = out_data.rx;
  assign ack_error   = out_data.err;

endmodule

/* design/i2cm_checker.sv */
// Port-level checker for the I2C master bit sequencer, bound to the top level.
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rx_byte,
  input logic       scl_out
);

  // done beat always reports the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done_res with busy_res set");

  // input only stalls when the output side holds a beat
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending output beat");

  // both channels come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("channel not empty after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(rx_byte) && $stable(scl_out)))
    else $error("stalled output beat changed");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .rx_byte   (rx_byte),
  .scl_out   (scl_out)
);
